FILE: sv/packed_ternary_row_dot_top_macros.svh
// assertion macros for the ternary row dot block
`ifndef PACKED_TERNARY_ROW_DOT_TOP_MACROS_SVH
`define PACKED_TERNARY_ROW_DOT_TOP_MACROS_SVH

// same-cycle implication
`define PTRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptrd assertion failed");

// next-cycle implication
`define PTRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptrd assertion failed");

`endif

FILE: sv/ptrd_pkg.sv
`timescale 1ns / 1ps

package ptrd_pkg;

  localparam int unsigned LANE_FIELDS = 4;

  localparam logic [3:0] CODE_PLUS  = 4'h1;
  localparam logic [3:0] CODE_MINUS = 4'hF;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef logic signed [15:0] act_t;
  typedef logic signed [16:0] contrib_t;
  typedef logic signed [31:0] acc_t;

endpackage

FILE: sv/ptrd_lane.sv
`timescale 1ns / 1ps

module ptrd_lane
  import ptrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic       active_i,
  input  logic [3:0] code_i,
  input  act_t       act_i,
  output contrib_t   contrib_o
);

  contrib_t contrib_d, contrib_q;

  always_comb begin
    contrib_d = '0;
    if (active_i) begin
      case (code_i)
        CODE_PLUS:  contrib_d = contrib_t'(act_i);
        CODE_MINUS: contrib_d = -contrib_t'(act_i);
        default:    contrib_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      contrib_q <= contrib_d;
    end
  end

  assign contrib_o = contrib_q;

endmodule

FILE: sv/ptrd_merge.sv
`timescale 1ns / 1ps

module ptrd_merge
  import ptrd_pkg::*;
#(
  parameter int unsigned N_LANES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_l_i,
  input  logic        last_l_i,
  input  contrib_t    contrib_i [N_LANES],
  input  logic [23:0] scale_l_i,
  input  acc_t        bias_l_i,
  output logic        ready_l_o,
  output logic        valid_s_o,
  input  logic        ready_s_i,
  output acc_t        sum_s_o,
  output logic [23:0] scale_s_o,
  output acc_t        bias_s_o
);

  function automatic acc_t sat_add(acc_t a, contrib_t c);
    logic signed [32:0] s;
    s = {a[31], a} + 33'(c);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? S32_MIN : S32_MAX;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  acc_t        acc_d, acc_q, chain;
  logic        valid_s_q;
  acc_t        sum_s_q, bias_s_q;
  logic [23:0] scale_s_q;
  logic        adv_l, s_free;

  // lanes fold in order, each step saturating
  always_comb begin
    chain = acc_q;
    for (int i = 0; i < int'(N_LANES); i++) begin
      chain = sat_add(chain, contrib_i[i]);
    end
  end

  assign s_free    = !valid_s_q || ready_s_i;
  assign adv_l     = valid_l_i && (!last_l_i || s_free);
  assign ready_l_o = !valid_l_i || !last_l_i || s_free;
  assign acc_d     = last_l_i ? '0 : chain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      valid_s_q <= 1'b0;
    end else begin
      if (adv_l) begin
        acc_q <= acc_d;
      end
      if (s_free) begin
        valid_s_q <= adv_l && last_l_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_l && last_l_i) begin
      sum_s_q   <= chain;
      scale_s_q <= scale_l_i;
      bias_s_q  <= bias_l_i;
    end
  end

  assign valid_s_o = valid_s_q;
  assign sum_s_o   = sum_s_q;
  assign scale_s_o = scale_s_q;
  assign bias_s_o  = bias_s_q;

endmodule

FILE: sv/ptrd_scale.sv
`timescale 1ns / 1ps

module ptrd_scale
  import ptrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_s_i,
  output logic        ready_s_o,
  input  acc_t        sum_s_i,
  input  logic [23:0] scale_s_i,
  input  acc_t        bias_s_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output acc_t        row_result_o
);

  logic               valid_p_q, valid_o_q;
  logic signed [56:0] prod_d, prod_q;
  acc_t               bias_p_q;
  logic signed [40:0] shifted;
  logic signed [41:0] total;
  acc_t               res_d, res_q;
  logic               o_free, p_free;

  assign o_free    = !valid_o_q || !out_stall_i;
  assign p_free    = !valid_p_q || o_free;
  assign ready_s_o = p_free;

  assign prod_d = sum_s_i * $signed({1'b0, scale_s_i});

  // upper bits of the product give the floor of the shift
  assign shifted = $signed(prod_q[56:16]);
  assign total   = 42'(shifted) + 42'(bias_p_q);

  always_comb begin
    if (total > 42'(S32_MAX)) begin
      res_d = S32_MAX;
    end else if (total < 42'(S32_MIN)) begin
      res_d = S32_MIN;
    end else begin
      res_d = total[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
      valid_o_q <= 1'b0;
    end else begin
      if (p_free) begin
        valid_p_q <= valid_s_i;
      end
      if (o_free) begin
        valid_o_q <= valid_p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_free && valid_s_i) begin
      prod_q   <= prod_d;
      bias_p_q <= bias_s_i;
    end
    if (o_free && valid_p_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = valid_o_q;
  assign row_result_o = res_q;

endmodule

FILE: sv/packed_ternary_row_dot_top.sv
// ternary-weight row dot product with row scale and bias
//
// input channel (in_valid_i / in_stall_o): one transaction per cycle carries up
// to four activations, their 4-bit weight codes, the live lane count and the
// row_last flag; row_scale_i and row_bias_i matter only with row_last set
// output channel (out_valid_o / out_stall_i): one row_result_o per row, given
// on the transaction that closed the row
// throughput: one input transaction per cycle while in_stall_o is low, with a
// combinational saturating fold of lane contributions into the row accumulator
// the closing transaction's result is registered in turn in the lane register,
// merge stage, multiply stage and output register
// reset clears the accumulator and every stage valid; no clearing pass
// when the receiver stalls, results queue in the merge, multiply and output
// stages; non-closing transactions keep flowing into the accumulator, and
// in_stall_o rises only when a row-closing transaction finds no free stage
`timescale 1ns / 1ps

module packed_ternary_row_dot_top
  import ptrd_pkg::*;
#(
  parameter int unsigned LANES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        weight_codes_i,
  input  logic signed [15:0] act_lane0_i,
  input  logic signed [15:0] act_lane1_i,
  input  logic signed [15:0] act_lane2_i,
  input  logic signed [15:0] act_lane3_i,
  input  logic [2:0]         lanes_valid_i,
  input  logic               row_last_i,
  input  logic [23:0]        row_scale_i,
  input  logic signed [31:0] row_bias_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] row_result_o
);

`include "packed_ternary_row_dot_top_macros.svh"

  localparam int unsigned NL = (LANES < LANE_FIELDS) ? LANES : LANE_FIELDS;
  localparam logic [2:0]  NL_CNT = 3'(NL);

  act_t        acts [LANE_FIELDS];
  contrib_t    contrib [NL];
  logic [2:0]  cnt;
  logic        in_acc, ready_l;
  logic        valid_l_q, last_l_q;
  logic [23:0] scale_l_q;
  acc_t        bias_l_q;
  logic        valid_s, ready_s;
  acc_t        sum_s, bias_s;
  logic [23:0] scale_s;

  assign acts[0] = act_lane0_i;
  assign acts[1] = act_lane1_i;
  assign acts[2] = act_lane2_i;
  assign acts[3] = act_lane3_i;

  assign cnt        = (lanes_valid_i > NL_CNT) ? NL_CNT : lanes_valid_i;
  assign in_stall_o = !ready_l;
  assign in_acc     = in_valid_i && ready_l;

  for (genvar g = 0; g < int'(NL); g++) begin : g_lane
    ptrd_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (in_acc),
      .active_i (3'(g) < cnt),
      .code_i   (weight_codes_i[4*g +: 4]),
      .act_i    (acts[g]),
      .contrib_o(contrib[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_l_q <= 1'b0;
    end else if (ready_l) begin
      valid_l_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_l_q  <= row_last_i;
      scale_l_q <= row_scale_i;
      bias_l_q  <= row_bias_i;
    end
  end

  ptrd_merge #(
    .N_LANES(NL)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_l_i(valid_l_q),
    .last_l_i (last_l_q),
    .contrib_i(contrib),
    .scale_l_i(scale_l_q),
    .bias_l_i (bias_l_q),
    .ready_l_o(ready_l),
    .valid_s_o(valid_s),
    .ready_s_i(ready_s),
    .sum_s_o  (sum_s),
    .scale_s_o(scale_s),
    .bias_s_o (bias_s)
  );

  ptrd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_s_i   (valid_s),
    .ready_s_o   (ready_s),
    .sum_s_i     (sum_s),
    .scale_s_i   (scale_s),
    .bias_s_i    (bias_s),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_result_o(row_result_o)
  );

  // only a waiting row-closing transaction may hold the input
  `PTRD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, valid_l_q && last_l_q && valid_s)
  `PTRD_ASSERT_IMP(a_mid_row_flows, clk_i, rst_ni, valid_l_q && !last_l_q, !in_stall_o)
  `PTRD_ASSERT_NXT(a_sum_held, clk_i, rst_ni, valid_s && !ready_s, valid_s && $stable(sum_s))

endmodule
